### rtl/sst_pkg.sv
// Shared types, codes and character-class functions for the source tokenizer.
// Used by every module of the block; depends on nothing else.
package sst_pkg;

  // Width of the internal position counters. Positions shown on the port saturate at 16 bits.
  localparam int PosBits = 16;
  localparam int PosWide = (PosBits > 16) ? PosBits : 16;

  // Scanner modes.
  localparam logic [3:0] MODE_IDLE = 4'd0;
  localparam logic [3:0] MODE_WORD = 4'd1;
  localparam logic [3:0] MODE_NUM  = 4'd2;
  localparam logic [3:0] MODE_STR  = 4'd3;
  localparam logic [3:0] MODE_EQ   = 4'd4;
  localparam logic [3:0] MODE_BANG = 4'd5;
  localparam logic [3:0] MODE_LT   = 4'd6;
  localparam logic [3:0] MODE_GT   = 4'd7;

  // Token kinds.
  localparam logic [4:0] KIND_EOF     = 5'd0;
  localparam logic [4:0] KIND_INT     = 5'd1;
  localparam logic [4:0] KIND_FLOAT   = 5'd2;
  localparam logic [4:0] KIND_STRING  = 5'd3;
  localparam logic [4:0] KIND_IDENT   = 5'd4;
  localparam logic [4:0] KIND_GROWL   = 5'd5;
  localparam logic [4:0] KIND_LET     = 5'd6;
  localparam logic [4:0] KIND_IF      = 5'd7;
  localparam logic [4:0] KIND_ELIF    = 5'd8;
  localparam logic [4:0] KIND_ELSE    = 5'd9;
  localparam logic [4:0] KIND_FOR     = 5'd10;
  localparam logic [4:0] KIND_WHILE   = 5'd11;
  localparam logic [4:0] KIND_TRUE    = 5'd12;
  localparam logic [4:0] KIND_FALSE   = 5'd13;
  localparam logic [4:0] KIND_HONEY   = 5'd14;
  localparam logic [4:0] KIND_EQEQ    = 5'd15;
  localparam logic [4:0] KIND_NE      = 5'd16;
  localparam logic [4:0] KIND_LE      = 5'd17;
  localparam logic [4:0] KIND_GE      = 5'd18;
  localparam logic [4:0] KIND_LT      = 5'd19;
  localparam logic [4:0] KIND_GT      = 5'd20;
  localparam logic [4:0] KIND_PLUS    = 5'd21;
  localparam logic [4:0] KIND_MINUS   = 5'd22;
  localparam logic [4:0] KIND_STAR    = 5'd23;
  localparam logic [4:0] KIND_SLASH   = 5'd24;
  localparam logic [4:0] KIND_PERCENT = 5'd25;
  localparam logic [4:0] KIND_LPAREN  = 5'd26;
  localparam logic [4:0] KIND_RPAREN  = 5'd27;
  localparam logic [4:0] KIND_ASSIGN  = 5'd28;
  localparam logic [4:0] KIND_COLON   = 5'd29;
  localparam logic [4:0] KIND_UNKNOWN = 5'd30;
  localparam logic [4:0] KIND_ERROR   = 5'd31;

  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] start;
    logic [15:0] len;
    logic        last;
  } result_t;

  // Up to two results produced by one scanned byte, in emission order.
  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } push_t;

  function automatic logic is_space(logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_word(logic [7:0] c);
    return is_alpha(c) || is_digit(c) || c == "_";
  endfunction

  function automatic logic [15:0] sat_out(logic [PosBits-1:0] v);
    logic [PosWide-1:0] w;
    w = PosWide'(v);
    if (w > PosWide'(65535)) begin
      return 16'hFFFF;
    end
    return w[15:0];
  endfunction

  function automatic logic [4:0] single_kind(logic [7:0] c);
    logic [4:0] k;
    case (c)
      "+":     k = KIND_PLUS;
      "-":     k = KIND_MINUS;
      "*":     k = KIND_STAR;
      "/":     k = KIND_SLASH;
      "%":     k = KIND_PERCENT;
      "(":     k = KIND_LPAREN;
      ")":     k = KIND_RPAREN;
      "=":     k = KIND_ASSIGN;
      ":":     k = KIND_COLON;
      "<":     k = KIND_LT;
      ">":     k = KIND_GT;
      default: k = KIND_UNKNOWN;
    endcase
    return k;
  endfunction

  // Only the first len bytes of the prefix are compared, so unwritten bytes never matter.
  function automatic logic [4:0] word_kind(logic [4:0][7:0] p, logic [2:0] len);
    logic [39:0] w5;
    logic [31:0] w4;
    logic [23:0] w3;
    logic [15:0] w2;
    logic [4:0]  k;
    w5 = {p[0], p[1], p[2], p[3], p[4]};
    w4 = {p[0], p[1], p[2], p[3]};
    w3 = {p[0], p[1], p[2]};
    w2 = {p[0], p[1]};
    k  = KIND_IDENT;
    case (len)
      3'd2: begin
        if (w2 == "if") k = KIND_IF;
      end
      3'd3: begin
        if (w3 == "let") k = KIND_LET;
        else if (w3 == "str") k = KIND_STRING;
        else if (w3 == "int") k = KIND_INT;
        else if (w3 == "for") k = KIND_FOR;
      end
      3'd4: begin
        if (w4 == "elif") k = KIND_ELIF;
        else if (w4 == "else") k = KIND_ELSE;
        else if (w4 == "TRUE") k = KIND_TRUE;
      end
      3'd5: begin
        if (w5 == "growl") k = KIND_GROWL;
        else if (w5 == "float") k = KIND_FLOAT;
        else if (w5 == "while") k = KIND_WHILE;
        else if (w5 == "FALSE") k = KIND_FALSE;
        else if (w5 == "honey") k = KIND_HONEY;
      end
      default: k = KIND_IDENT;
    endcase
    return k;
  endfunction

endpackage

### rtl/sst_scan.sv
// Input holding register and scanner state machine of the source tokenizer.
// Scans one byte per cycle while the queue has room, into up to two results; depends on sst_pkg.
module sst_scan (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,
  input  logic                room,
  output sst_pkg::push_t      push
);

  logic                        held_valid;
  logic [7:0]                  held_ch;
  logic                        fire;

  logic [3:0]                  mode, mode_next;
  logic [sst_pkg::PosBits-1:0] position, position_next;
  logic [sst_pkg::PosBits-1:0] token_start, token_start_next;
  logic [4:0][7:0]             word_prefix;
  logic [2:0]                  word_length, word_length_next;
  logic                        seen_dot, seen_dot_next;
  logic [7:0]                  open_quote, open_quote_next;

  logic                        pre_we;
  logic [2:0]                  pre_idx;
  logic [sst_pkg::PosBits-1:0] pos_inc;
  logic [sst_pkg::PosBits-1:0] span;
  logic                        run_idle;
  logic                        do_reset;
  logic                        pend_v, sec_v;
  sst_pkg::result_t            pend, sec;
  logic [7:0]                  c;

  assign fire     = held_valid && room;
  assign s_tready = !held_valid || room;
  assign c        = held_ch;

  assign pos_inc = (position == {sst_pkg::PosBits{1'b1}}) ? position
                                                          : position + 1'b1;
  assign span    = (position >= token_start) ? position - token_start : '0;

  always_comb begin
    mode_next        = mode;
    position_next    = position;
    token_start_next = token_start;
    word_length_next = word_length;
    seen_dot_next    = seen_dot;
    open_quote_next  = open_quote;
    pre_we           = 1'b0;
    pre_idx          = word_length;
    run_idle         = 1'b0;
    do_reset         = 1'b0;
    pend_v           = 1'b0;
    sec_v            = 1'b0;
    pend             = '0;
    sec              = '0;

    unique case (mode) inside
      sst_pkg::MODE_WORD: begin
        if (sst_pkg::is_word(c)) begin
          if (word_length < 3'd5) pre_we = 1'b1;
          if (word_length < 3'd6) word_length_next = word_length + 3'd1;
          position_next = pos_inc;
        end else begin
          pend_v     = 1'b1;
          pend.kind  = sst_pkg::word_kind(word_prefix, word_length);
          pend.start = sst_pkg::sat_out(token_start);
          pend.len   = sst_pkg::sat_out(span);
          run_idle   = 1'b1;
        end
      end
      sst_pkg::MODE_NUM: begin
        if (sst_pkg::is_digit(c) || (c == "." && !seen_dot)) begin
          if (c == ".") seen_dot_next = 1'b1;
          position_next = pos_inc;
        end else begin
          pend_v     = 1'b1;
          pend.kind  = seen_dot ? sst_pkg::KIND_FLOAT : sst_pkg::KIND_INT;
          pend.start = sst_pkg::sat_out(token_start);
          pend.len   = sst_pkg::sat_out(span);
          run_idle   = 1'b1;
        end
      end
      sst_pkg::MODE_STR: begin
        sec.start = sst_pkg::sat_out(token_start);
        sec.len   = sst_pkg::sat_out(span);
        if (c == 8'd0) begin
          sec_v    = 1'b1;
          sec.kind = sst_pkg::KIND_ERROR;
          do_reset = 1'b1;
        end else begin
          if (c == open_quote) begin
            sec_v     = 1'b1;
            sec.kind  = sst_pkg::KIND_STRING;
            mode_next = sst_pkg::MODE_IDLE;
          end
          position_next = pos_inc;
        end
      end
      sst_pkg::MODE_EQ, sst_pkg::MODE_BANG, sst_pkg::MODE_LT, sst_pkg::MODE_GT: begin
        if (c == "=") begin
          sec_v         = 1'b1;
          sec.kind      = sst_pkg::KIND_EQEQ + 5'(mode - sst_pkg::MODE_EQ);
          sec.start     = sst_pkg::sat_out(token_start);
          sec.len       = 16'd2;
          mode_next     = sst_pkg::MODE_IDLE;
          position_next = pos_inc;
        end else begin
          pend_v     = 1'b1;
          pend.start = sst_pkg::sat_out(token_start);
          pend.len   = 16'd1;
          if (mode == sst_pkg::MODE_EQ) pend.kind = sst_pkg::KIND_ASSIGN;
          else if (mode == sst_pkg::MODE_BANG) pend.kind = sst_pkg::KIND_UNKNOWN;
          else if (mode == sst_pkg::MODE_LT) pend.kind = sst_pkg::KIND_LT;
          else pend.kind = sst_pkg::KIND_GT;
          run_idle = 1'b1;
        end
      end
      default: run_idle = 1'b1;
    endcase

    // The byte that closed a pending token is scanned again from idle.
    if (run_idle) begin
      mode_next = sst_pkg::MODE_IDLE;
      if (c == 8'd0) begin
        sec_v     = 1'b1;
        sec.kind  = sst_pkg::KIND_EOF;
        sec.start = sst_pkg::sat_out(position);
        sec.len   = 16'd0;
        do_reset  = 1'b1;
      end else begin
        position_next = pos_inc;
        if (!sst_pkg::is_space(c)) begin
          token_start_next = position;
          if (sst_pkg::is_alpha(c) || c == "_") begin
            mode_next        = sst_pkg::MODE_WORD;
            pre_we           = 1'b1;
            pre_idx          = 3'd0;
            word_length_next = 3'd1;
          end else if (sst_pkg::is_digit(c)) begin
            mode_next     = sst_pkg::MODE_NUM;
            seen_dot_next = 1'b0;
          end else if (c == "\"" || c == "'") begin
            mode_next        = sst_pkg::MODE_STR;
            open_quote_next  = c;
            token_start_next = pos_inc;
          end else if (c == "=") begin
            mode_next = sst_pkg::MODE_EQ;
          end else if (c == "!") begin
            mode_next = sst_pkg::MODE_BANG;
          end else if (c == "<") begin
            mode_next = sst_pkg::MODE_LT;
          end else if (c == ">") begin
            mode_next = sst_pkg::MODE_GT;
          end else begin
            sec_v     = 1'b1;
            sec.kind  = sst_pkg::single_kind(c);
            sec.start = sst_pkg::sat_out(position);
            sec.len   = 16'd1;
          end
        end
      end
    end

    // End of source returns the scanner to its reset state.
    if (do_reset) begin
      mode_next        = sst_pkg::MODE_IDLE;
      position_next    = '0;
      token_start_next = '0;
      word_length_next = 3'd0;
      seen_dot_next    = 1'b0;
      open_quote_next  = 8'd0;
    end
  end

  always_comb begin
    push.count   = fire ? (2'(pend_v) + 2'(sec_v)) : 2'd0;
    push.r0      = pend_v ? pend : sec;
    push.r0.last = !(pend_v && sec_v);
    push.r1      = sec;
    push.r1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid  <= 1'b0;
      mode        <= sst_pkg::MODE_IDLE;
      position    <= '0;
      token_start <= '0;
      word_length <= 3'd0;
      seen_dot    <= 1'b0;
      open_quote  <= 8'd0;
    end else begin
      if (s_tvalid && s_tready) begin
        held_valid <= 1'b1;
      end else if (fire) begin
        held_valid <= 1'b0;
      end
      if (fire) begin
        mode        <= mode_next;
        position    <= position_next;
        token_start <= token_start_next;
        word_length <= word_length_next;
        seen_dot    <= seen_dot_next;
        open_quote  <= open_quote_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      held_ch <= s_tdata;
    end
    if (fire && pre_we) begin
      word_prefix[pre_idx] <= c;
    end
  end

endmodule

### rtl/sst_queue.sv
// Three-entry result queue of the source tokenizer, head at entry zero.
// Takes up to two results a cycle and drives the master side; depends on sst_pkg.
module sst_queue (
  input  logic              clk,
  input  logic              rst,
  input  sst_pkg::push_t    push,
  output logic              room,
  output logic              m_tvalid,
  input  logic              m_tready,
  output sst_pkg::result_t  head
);

  sst_pkg::result_t entry [3];
  sst_pkg::result_t entry_next [3];
  logic [1:0]       count, count_next;
  logic [1:0]       kept;
  logic             pop;

  assign m_tvalid = count != 2'd0;
  assign pop      = m_tvalid && m_tready;
  assign kept     = count - 2'(pop);
  // Two free entries are needed, since one byte can produce two results.
  assign room     = kept <= 2'd1;
  assign head     = entry[0];

  always_comb begin
    entry_next[0] = pop ? entry[1] : entry[0];
    entry_next[1] = pop ? entry[2] : entry[1];
    entry_next[2] = entry[2];
    for (int i = 0; i < 3; i++) begin
      if (push.count != 2'd0 && 2'(i) == kept) entry_next[i] = push.r0;
      if (push.count == 2'd2 && 2'(i) == kept + 2'd1) entry_next[i] = push.r1;
    end
    count_next = kept + push.count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      entry[i] <= entry_next[i];
    end
  end

endmodule

### rtl/script_source_tokenizer_top.sv
// Top level of the source tokenizer: scanner followed by the result queue.
// Depends on sst_pkg, sst_scan and sst_queue.
//
// Source bytes arrive on the slave stream (s_tdata = ch), one byte per transfer; a zero
// byte ends the source. Tokens leave on the master stream, one token per transfer.
// A byte is held in an input register and scanned once the queue has room; its results are
// written to a three-entry queue register, from which the first result is offered. The
// scanner takes one byte per cycle while the queue has two free entries after the current
// output transfer; with the receiver always ready this gives one byte per cycle, and a
// byte that yields two tokens occupies the master side for two transfers. m_tlast marks
// the final token caused by a byte. When the receiver stalls, bytes that close no token
// keep flowing; once two results wait in the queue and a further byte is held, s_tready
// drops until the queue drains, and nothing is lost. Reset empties the queue and the input
// register and returns the scanner to idle with position zero; the end of source does the
// same to the scanner after its last token.
module script_source_tokenizer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] ch
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [4:0] token_kind, [20:5] token_offset, [36:21] text_length
  output logic        m_tlast
);

  sst_pkg::push_t   push;
  sst_pkg::result_t head;
  logic             room;

  sst_scan u_scan (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .room     (room),
    .push     (push)
  );

  sst_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .room     (room),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .head     (head)
  );

  assign m_tdata = {3'b000, head.len, head.start, head.kind};
  assign m_tlast = head.last;

endmodule

### rtl/sst_checker.sv
// Port-level checks for the source tokenizer, bound to the top level.
// Sees only the top-level ports; depends on sst_pkg for the token kinds.
module sst_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic        m_tlast
);

  // A stalled token holds its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled token changed");

  // Nothing is offered right after reset.
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("token offered after reset");

  // End of file has no text and is always the final token of its byte.
  a_eof: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[4:0] == sst_pkg::KIND_EOF |-> m_tdata[36:21] == 16'd0 && m_tlast)
    else $error("bad end-of-file token");

  // Two-byte comparisons are two bytes long and end their byte's results.
  a_cmp: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[4:0] == sst_pkg::KIND_EQEQ || m_tdata[4:0] == sst_pkg::KIND_NE ||
                 m_tdata[4:0] == sst_pkg::KIND_LE || m_tdata[4:0] == sst_pkg::KIND_GE)
    |-> m_tdata[36:21] == 16'd2 && m_tlast)
    else $error("bad comparison token");

  // An unterminated string error is always the final token of its byte.
  a_err: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[4:0] == sst_pkg::KIND_ERROR |-> m_tlast)
    else $error("error token not last");

endmodule

bind script_source_tokenizer_top sst_checker u_checker (.*);
